// File: hw/rtl/dps_pkg.sv
// shared widths, codes and constants for the discrete pid step block
package dps_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int DERIV_W    = ERR_W + 1;
  localparam int SUM_W      = 32;
  localparam int DRIVE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SEEN_W     = 2;

  localparam int PROP_P_W   = ERR_W + GAIN_W;
  localparam int INTEG_P_W  = SUM_W + GAIN_W;
  localparam int DERIV_P_W  = DERIV_W + GAIN_W;
  localparam int TOTAL_W    = INTEG_P_W - FRAC_BITS + 2;

  localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP  = 2'd0,
    CFG_GAIN_INTEG = 2'd1,
    CFG_GAIN_DERIV = 2'd2
  } cfg_idx_t;

endpackage

// File: hw/rtl/discrete_pid_step.sv
// discrete pid step: error, integral, derivative and gain-weighted drive per sample
//
// One drive result per request, one request per clock when the output side keeps
// up; four register stages (input register, error and integral update, three gain
// multiplies in parallel, scale/sum/saturate into the output register), so m_tvalid
// rises once an accepted request has passed through all four. The integral and
// previous-error registers are updated in the second stage, so that 33-bit
// saturating add is the only loop and it closes through those registers. The first request
// after reset only counts as warm-up: its drive is the proportional term alone and
// the integral and previous error stay untouched.
// Gains are signed Q8.8; each product is divided by 256 rounding toward zero and
// the summed drive saturates to 32-bit signed. Gains may only be written while no
// request is in flight.
module discrete_pid_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [31:0]                    s_tdata,   // reading [15:0], setpoint [31:16]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  output logic [31:0]                    m_tdata,   // drive [31:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [dps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dps_pkg::GAIN_W-1:0]     cfg_data
);
  import dps_pkg::*;

  // gains
  logic signed [GAIN_W-1:0] gain_prop, gain_integ, gain_deriv;

  // loop state
  logic signed [SUM_W-1:0]  err_sum;
  logic signed [ERR_W-1:0]  last_err;
  logic [SEEN_W-1:0]        samples_seen;

  // pipeline registers
  logic                        v1, v2, v3, v4;
  logic signed [SAMPLE_W-1:0]  s1_reading, s1_setpoint;
  logic signed [ERR_W-1:0]     s2_err;
  logic signed [SUM_W-1:0]     s2_integ;
  logic signed [DERIV_W-1:0]   s2_deriv;
  logic signed [PROP_P_W-1:0]  s3_prop;
  logic signed [INTEG_P_W-1:0] s3_integ;
  logic signed [DERIV_P_W-1:0] s3_deriv;
  logic signed [DRIVE_W-1:0]   s4_drive;

  logic rdy2, rdy3, rdy4, in_acc, move1, move2, move3;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign s_tready = !v1 || rdy2;
  assign in_acc   = s_tvalid && s_tready;
  assign move1    = v1 && rdy2;
  assign move2    = v2 && rdy3;
  assign move3    = v3 && rdy4;

  assign m_tvalid = v4;
  assign m_tdata  = s4_drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (in_acc) v1 <= 1'b1;
      else if (move1) v1 <= 1'b0;
      if (move1) v2 <= 1'b1;
      else if (move2) v2 <= 1'b0;
      if (move2) v3 <= 1'b1;
      else if (move3) v3 <= 1'b0;
      if (move3) v4 <= 1'b1;
      else if (m_tready) v4 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= '0;
      gain_integ <= '0;
      gain_deriv <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_PROP:  gain_prop  <= cfg_data;
        CFG_GAIN_INTEG: gain_integ <= cfg_data;
        CFG_GAIN_DERIV: gain_deriv <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_reading  <= s_tdata[SAMPLE_W-1:0];
      s1_setpoint <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // stage 2: error, derivative, saturating integral
  logic signed [ERR_W-1:0]   err_c;
  logic signed [DERIV_W-1:0] deriv_c;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic                      full_c;

  assign err_c   = $signed({s1_setpoint[SAMPLE_W-1], s1_setpoint})
                 - $signed({s1_reading[SAMPLE_W-1], s1_reading});
  assign deriv_c = $signed({err_c[ERR_W-1], err_c})
                 - $signed({last_err[ERR_W-1], last_err});
  assign sum_wide = $signed({err_sum[SUM_W-1], err_sum})
                  + $signed({{(SUM_W+1-ERR_W){err_c[ERR_W-1]}}, err_c});
  // a sample that finds at least one earlier sample runs the full step
  assign full_c  = (samples_seen != '0);

  always_comb begin
    if (sum_wide[SUM_W] == sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W-1:0];
    end else if (sum_wide[SUM_W]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
      err_sum      <= '0;
      last_err     <= '0;
    end else if (move1) begin
      if (samples_seen != SEEN_FULL) samples_seen <= samples_seen + 1'b1;
      if (full_c) begin
        err_sum  <= sum_sat;
        last_err <= err_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      s2_err   <= err_c;
      // warm-up zeroes the integral and derivative operands
      s2_integ <= full_c ? sum_sat : '0;
      s2_deriv <= full_c ? deriv_c : '0;
    end
  end

  // stage 3: gain products
  always_ff @(posedge clk) begin
    if (move2) begin
      s3_prop  <= s2_err   * gain_prop;
      s3_integ <= s2_integ * gain_integ;
      s3_deriv <= s2_deriv * gain_deriv;
    end
  end

  // stage 4: divide by 256 toward zero, sum, saturate
  logic signed [PROP_P_W-1:0]  prop_adj;
  logic signed [INTEG_P_W-1:0] integ_adj;
  logic signed [DERIV_P_W-1:0] deriv_adj;
  logic signed [TOTAL_W-1:0]   total;
  logic signed [DRIVE_W-1:0]   drive_c;

  // negative products get 255 added before the arithmetic shift
  assign prop_adj  = s3_prop
                   + $signed({{(PROP_P_W-FRAC_BITS){1'b0}}, {FRAC_BITS{s3_prop[PROP_P_W-1]}}});
  assign integ_adj = s3_integ
                   + $signed({{(INTEG_P_W-FRAC_BITS){1'b0}},
                              {FRAC_BITS{s3_integ[INTEG_P_W-1]}}});
  assign deriv_adj = s3_deriv
                   + $signed({{(DERIV_P_W-FRAC_BITS){1'b0}},
                              {FRAC_BITS{s3_deriv[DERIV_P_W-1]}}});

  assign total =
      $signed({{(TOTAL_W-PROP_P_W+FRAC_BITS){prop_adj[PROP_P_W-1]}},
               prop_adj[PROP_P_W-1:FRAC_BITS]})
    + $signed({{(TOTAL_W-INTEG_P_W+FRAC_BITS){integ_adj[INTEG_P_W-1]}},
               integ_adj[INTEG_P_W-1:FRAC_BITS]})
    + $signed({{(TOTAL_W-DERIV_P_W+FRAC_BITS){deriv_adj[DERIV_P_W-1]}},
               deriv_adj[DERIV_P_W-1:FRAC_BITS]});

  always_comb begin
    if ((&total[TOTAL_W-1:DRIVE_W-1]) || !(|total[TOTAL_W-1:DRIVE_W-1])) begin
      drive_c = total[DRIVE_W-1:0];
    end else if (total[TOTAL_W-1]) begin
      drive_c = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_c = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (move3) s4_drive <= drive_c;
  end

`ifndef NO_ASSERTIONS
  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    samples_seen != 2'd3)
    else $error("sample count out of range");

  a_seen_holds: assert property (@(posedge clk) disable iff (rst)
    samples_seen == SEEN_FULL |=> samples_seen == SEEN_FULL)
    else $error("sample count left the full state");

  a_warmup_state: assert property (@(posedge clk) disable iff (rst)
    move1 && samples_seen == '0 |=> $stable(err_sum) && $stable(last_err))
    else $error("loop state changed on warm-up sample");

  a_warmup_operands: assert property (@(posedge clk) disable iff (rst)
    move1 && samples_seen == '0 |=> s2_integ == '0 && s2_deriv == '0)
    else $error("warm-up sample carries integral or derivative");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && v3 && v4 && !m_tready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
